[src/iem_pkg.sv]
`timescale 1ns / 1ps

package iem_pkg;

    // Write buffer depth and the widths that follow from it.
    localparam int BUF_DEPTH = 16;
    localparam int BUF_IDX_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int BUF_CNT_W = $clog2(BUF_DEPTH + 1);

    localparam int FUNC_W     = 2;
    localparam int ADDR_W     = 8;
    localparam int COUNT_W    = 5;
    localparam int DATA_W     = 8;
    localparam int DEV_W      = 7;
    localparam int PHASE_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0]   BUF_DEPTH_CNT  = COUNT_W'(BUF_DEPTH);
    localparam logic [BUF_CNT_W-1:0] BUF_DEPTH_FILL = BUF_CNT_W'(BUF_DEPTH);

    // Depth of the two small queues.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NACK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE    = 1'b1;

    localparam logic [DEV_W-1:0]   DEV_ADDR_RESET = 7'd80;
    localparam logic [PHASE_W-1:0] PHASE_RESET    = 16'd1;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_WRITE,
        CMD_READ,
        CMD_LOAD
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic [ADDR_W-1:0]  mem_addr;
        logic [COUNT_W-1:0] byte_count;
        logic [DATA_W-1:0]  data_byte;
        logic               sda_in;
    } t_item;

    typedef struct packed {
        logic                scl_out;
        logic                sda_low;
        logic [DATA_W-1:0]   read_data;
        logic                read_valid;
        logic                last_byte;
        logic                busy_res;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

[src/iem_front.sv]
`timescale 1ns / 1ps

module iem_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [iem_pkg::FUNC_W-1:0]        i_func,
    input  logic [iem_pkg::ADDR_W-1:0]        i_mem_addr,
    input  logic [iem_pkg::COUNT_W-1:0]       i_byte_count,
    input  logic [iem_pkg::DATA_W-1:0]        i_data_byte,
    input  logic                              i_sda_in,
    output logic                              o_item_valid,
    output iem_pkg::t_item                    o_item,
    input  logic                              i_item_take
);
    import iem_pkg::*;

    t_item                r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_cnt;
    t_item                w_item;
    logic                 w_push;
    logic                 w_pop;

    // Decode the command and bring the byte count into the range the
    // command uses, so the bus engine sees a ready-made length.
    always_comb begin
        w_item.mem_addr   = i_mem_addr;
        w_item.data_byte  = i_data_byte;
        w_item.sda_in     = i_sda_in;
        w_item.byte_count = i_byte_count;
        case (i_func)
            FUNC_TICK: begin
                w_item.cmd = CMD_TICK;
            end
            FUNC_WRITE: begin
                w_item.cmd = CMD_WRITE;
                if (int'(i_byte_count) > BUF_DEPTH) begin
                    w_item.byte_count = BUF_DEPTH_CNT;
                end
            end
            FUNC_READ: begin
                w_item.cmd = CMD_READ;
                if (i_byte_count == '0) begin
                    w_item.byte_count = COUNT_W'(1);
                end
            end
            FUNC_LOAD: begin
                w_item.cmd = CMD_LOAD;
            end
            default: begin
                w_item.cmd = CMD_TICK;
            end
        endcase
    end

    assign full         = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign w_push       = push && !full;
    assign o_item_valid = (r_cnt != '0);
    assign w_pop        = i_item_take && o_item_valid;
    assign o_item       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_front_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cnt) <= Q_DEPTH)
        else $error("front queue count beyond depth");

endmodule

[src/iem_core.sv]
`timescale 1ns / 1ps

module iem_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [iem_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [iem_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              i_item_valid,
    input  iem_pkg::t_item                    i_item,
    output logic                              o_item_take,
    input  logic                              i_res_full,
    output logic                              o_res_push,
    output iem_pkg::t_result                  o_res
);
    import iem_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_WBIT,
        PH_WACK,
        PH_RBIT,
        PH_MACK,
        PH_STOP
    } t_phase;

    typedef enum logic [2:0] {
        ST_DEVW,
        ST_WORD,
        ST_DATA,
        ST_DEVR,
        ST_READ
    } t_stage;

    logic [DEV_W-1:0]     r_dev_addr;
    logic [PHASE_W-1:0]   r_phase_ticks;

    t_phase               r_phase,      n_phase;
    t_stage               r_stage,      n_stage;
    logic [1:0]           r_quarter,    n_quarter;
    logic                 r_is_read,    n_is_read;
    logic                 r_nack,       n_nack;
    logic [3:0]           r_bit,        n_bit;
    logic [DATA_W-1:0]    r_shift,      n_shift;
    logic [COUNT_W-1:0]   r_bytes_left, n_bytes_left;
    logic [PHASE_W-1:0]   r_tick,       n_tick;
    logic [BUF_CNT_W-1:0] r_fill,       n_fill;
    logic [ADDR_W-1:0]    r_word,       n_word;
    logic [BUF_CNT_W-1:0] r_send_pos,   n_send_pos;

    logic [DATA_W-1:0]    r_wbuf [BUF_DEPTH];
    logic [DATA_W-1:0]    r_wbuf_rd;

    logic                 w_fire;
    logic                 w_busy;
    logic                 w_load;
    logic                 w_mid;
    logic [PHASE_W-1:0]   w_period;
    logic [PHASE_W:0]     w_tick_inc;
    t_result              w_res;

    assign w_fire      = i_item_valid && !i_res_full;
    assign o_item_take = w_fire;
    assign o_res_push  = w_fire;
    assign o_res       = w_res;
    assign w_busy      = (r_phase != PH_IDLE);
    assign w_period    = (r_phase_ticks == '0) ? PHASE_W'(1) : r_phase_ticks;
    assign w_tick_inc  = {1'b0, r_tick} + 1'b1;

    always_comb begin
        n_phase      = r_phase;
        n_stage      = r_stage;
        n_quarter    = r_quarter;
        n_is_read    = r_is_read;
        n_nack       = r_nack;
        n_bit        = r_bit;
        n_shift      = r_shift;
        n_bytes_left = r_bytes_left;
        n_tick       = r_tick;
        n_fill       = r_fill;
        n_word       = r_word;
        n_send_pos   = r_send_pos;
        w_load       = 1'b0;

        w_res.read_data  = '0;
        w_res.read_valid = 1'b0;
        w_res.last_byte  = 1'b0;
        w_res.status     = STATUS_NONE;

        case (i_item.cmd)
            CMD_WRITE, CMD_READ: begin
                if (!w_busy) begin
                    n_is_read    = (i_item.cmd == CMD_READ);
                    n_nack       = 1'b0;
                    n_word       = i_item.mem_addr;
                    n_bytes_left = i_item.byte_count;
                    n_send_pos   = '0;
                    n_stage      = ST_DEVW;
                    n_bit        = '0;
                    n_shift      = '0;
                    n_tick       = '0;
                    n_quarter    = '0;
                    n_phase      = PH_START;
                end
            end
            CMD_LOAD: begin
                if (!w_busy && r_fill < BUF_DEPTH_FILL) begin
                    w_load = 1'b1;
                    n_fill = r_fill + 1'b1;
                end
            end
            CMD_TICK: begin
                if (w_busy) begin
                    if (w_tick_inc >= {1'b0, w_period}) begin
                        n_tick = '0;
                        // Slave ACK and read data are sampled at the end of the
                        // second quarter, while SCL is high.
                        if (r_quarter == 2'd1) begin
                            if (r_phase == PH_WACK && i_item.sda_in) begin
                                n_nack = 1'b1;
                            end else if (r_phase == PH_RBIT) begin
                                n_shift = {r_shift[DATA_W-2:0], i_item.sda_in};
                            end
                        end
                        if (r_quarter == 2'd3) begin
                            n_quarter = '0;
                            case (r_phase)
                                PH_START: begin
                                    n_shift = {r_dev_addr, (r_stage == ST_DEVR)};
                                    n_bit   = '0;
                                    n_phase = PH_WBIT;
                                end
                                PH_WBIT: begin
                                    n_shift = {r_shift[DATA_W-2:0], 1'b0};
                                    n_bit   = r_bit + 1'b1;
                                    if (n_bit >= 4'd8) begin
                                        n_phase = PH_WACK;
                                    end
                                end
                                PH_WACK: begin
                                    if (r_nack) begin
                                        n_phase = PH_STOP;
                                    end else if (r_stage == ST_DEVW) begin
                                        n_stage = ST_WORD;
                                        n_shift = r_word;
                                        n_bit   = '0;
                                        n_phase = PH_WBIT;
                                    end else if (r_stage == ST_WORD && r_is_read) begin
                                        n_stage = ST_DEVR;
                                        n_phase = PH_START;
                                    end else if (r_stage == ST_DEVR) begin
                                        n_stage = ST_READ;
                                        n_shift = '0;
                                        n_bit   = '0;
                                        n_phase = PH_RBIT;
                                    end else if (r_bytes_left == '0) begin
                                        n_phase = PH_STOP;
                                    end else begin
                                        n_send_pos   = r_send_pos + 1'b1;
                                        n_bytes_left = r_bytes_left - 1'b1;
                                        n_stage      = ST_DATA;
                                        n_shift      = r_wbuf_rd;
                                        n_bit        = '0;
                                        n_phase      = PH_WBIT;
                                    end
                                end
                                PH_RBIT: begin
                                    n_bit = r_bit + 1'b1;
                                    if (n_bit >= 4'd8) begin
                                        w_res.read_data  = r_shift;
                                        w_res.read_valid = 1'b1;
                                        w_res.last_byte  = (r_bytes_left == COUNT_W'(1));
                                        if (r_bytes_left != '0) begin
                                            n_bytes_left = r_bytes_left - 1'b1;
                                        end
                                        n_phase = PH_MACK;
                                    end
                                end
                                PH_MACK: begin
                                    if (r_bytes_left == '0) begin
                                        n_phase = PH_STOP;
                                    end else begin
                                        n_shift = '0;
                                        n_bit   = '0;
                                        n_phase = PH_RBIT;
                                    end
                                end
                                PH_STOP: begin
                                    n_phase      = PH_IDLE;
                                    w_res.status = r_nack ? STATUS_NACK : STATUS_OK;
                                    if (!r_is_read) begin
                                        n_fill = '0;
                                    end
                                end
                                default: begin
                                    n_phase = PH_IDLE;
                                end
                            endcase
                        end else begin
                            n_quarter = r_quarter + 1'b1;
                        end
                    end else begin
                        n_tick = w_tick_inc[PHASE_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase

        // Bus levels as they stand after this item.
        w_mid = (n_quarter == 2'd1) || (n_quarter == 2'd2);
        case (n_phase)
            PH_START: begin
                w_res.scl_out = w_mid;
                w_res.sda_low = (n_quarter >= 2'd2);
            end
            PH_WBIT: begin
                w_res.scl_out = w_mid;
                w_res.sda_low = !n_shift[DATA_W-1];
            end
            PH_WACK, PH_RBIT: begin
                w_res.scl_out = w_mid;
                w_res.sda_low = 1'b0;
            end
            PH_MACK: begin
                w_res.scl_out = w_mid;
                w_res.sda_low = (n_bytes_left != '0);
            end
            PH_STOP: begin
                w_res.scl_out = (n_quarter >= 2'd1);
                w_res.sda_low = (n_quarter <= 2'd1);
            end
            default: begin
                w_res.scl_out = 1'b1;
                w_res.sda_low = 1'b0;
            end
        endcase
        w_res.busy_res = (n_phase != PH_IDLE);
    end

    // Write buffer; the entry at the send position is read into a register ahead,
    // long before the bus needs it.
    always_ff @(posedge i_clk) begin
        if (w_fire && w_load) begin
            r_wbuf[r_fill[BUF_IDX_W-1:0]] <= i_item.data_byte;
        end
        r_wbuf_rd <= r_wbuf[r_send_pos[BUF_IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr    <= DEV_ADDR_RESET;
            r_phase_ticks <= PHASE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEV_ADDR: r_dev_addr    <= i_cfg_wdata[DEV_W-1:0];
                CFG_PHASE:    r_phase_ticks <= i_cfg_wdata[PHASE_W-1:0];
                default:      r_dev_addr    <= r_dev_addr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_stage      <= ST_DEVW;
            r_quarter    <= '0;
            r_is_read    <= 1'b0;
            r_nack       <= 1'b0;
            r_bit        <= '0;
            r_shift      <= '0;
            r_bytes_left <= '0;
            r_tick       <= '0;
            r_fill       <= '0;
            r_word       <= '0;
            r_send_pos   <= '0;
        end else if (w_fire) begin
            r_phase      <= n_phase;
            r_stage      <= n_stage;
            r_quarter    <= n_quarter;
            r_is_read    <= n_is_read;
            r_nack       <= n_nack;
            r_bit        <= n_bit;
            r_shift      <= n_shift;
            r_bytes_left <= n_bytes_left;
            r_tick       <= n_tick;
            r_fill       <= n_fill;
            r_word       <= n_word;
            r_send_pos   <= n_send_pos;
        end
    end

    a_last_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_res.last_byte |-> w_res.read_valid)
        else $error("last byte flagged without a received byte");

    a_status_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && (w_res.status != STATUS_NONE) |-> !w_res.busy_res)
        else $error("finish status while the bus is still busy");

    a_idle_bus_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && !w_res.busy_res |-> w_res.scl_out && !w_res.sda_low)
        else $error("bus not released while idle");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) <= BUF_DEPTH)
        else $error("write buffer fill beyond depth");

endmodule

[src/iem_rslt_q.sv]
`timescale 1ns / 1ps

module iem_rslt_q (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  iem_pkg::t_result  i_res,
    output logic              o_full,
    output logic              empty,
    input  logic              pop,
    output iem_pkg::t_result  o_res
);
    import iem_pkg::*;

    t_result            r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_full = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign empty  = (r_cnt == '0);
    assign w_push = i_push && !o_full;
    assign w_pop  = pop && !empty;
    assign o_res  = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[src/i2c_eeprom_master.sv]
`timescale 1ns / 1ps

// Channel   Ports                                          Transfer when
// ------    ---------------------------------------------  ----------------
// items     push, full, i_func, i_mem_addr, i_byte_count,  push && !full
//           i_data_byte, i_sda_in
// results   empty, pop, o_scl_out, o_sda_low, o_read_data, pop && !empty
//           o_read_valid, o_last_byte, o_busy_res, o_status
// config    i_cfg_we, i_cfg_idx, i_cfg_wdata               i_cfg_we
//
// One item per cycle sustained while results are popped; each item gives one result.
// An accepted item is registered in the item queue, then stepped by the bus engine,
// which writes its result into the result queue, from where it can be popped.
// Reset is synchronous; there is no clearing pass, the bus comes out idle.
// With pop held low the engine stops once the two-entry result queue is full;
// full rises when the two-entry item queue has filled behind it.

module i2c_eeprom_master (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [iem_pkg::FUNC_W-1:0]        i_func,
    input  logic [iem_pkg::ADDR_W-1:0]        i_mem_addr,
    input  logic [iem_pkg::COUNT_W-1:0]       i_byte_count,
    input  logic [iem_pkg::DATA_W-1:0]        i_data_byte,
    input  logic                              i_sda_in,
    input  logic                              i_cfg_we,
    input  logic [iem_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [iem_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_scl_out,
    output logic                              o_sda_low,
    output logic [iem_pkg::DATA_W-1:0]        o_read_data,
    output logic                              o_read_valid,
    output logic                              o_last_byte,
    output logic                              o_busy_res,
    output logic [iem_pkg::STATUS_W-1:0]      o_status
);
    import iem_pkg::*;

    logic    w_item_valid;
    t_item   w_item;
    logic    w_item_take;
    logic    w_res_full;
    logic    w_res_push;
    t_result w_res;
    t_result w_res_out;

    iem_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_func       (i_func),
        .i_mem_addr   (i_mem_addr),
        .i_byte_count (i_byte_count),
        .i_data_byte  (i_data_byte),
        .i_sda_in     (i_sda_in),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_item_take  (w_item_take)
    );

    iem_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_take  (w_item_take),
        .i_res_full   (w_res_full),
        .o_res_push   (w_res_push),
        .o_res        (w_res)
    );

    iem_rslt_q u_rslt_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res),
        .o_full  (w_res_full),
        .empty   (empty),
        .pop     (pop),
        .o_res   (w_res_out)
    );

    assign o_scl_out    = w_res_out.scl_out;
    assign o_sda_low    = w_res_out.sda_low;
    assign o_read_data  = w_res_out.read_data;
    assign o_read_valid = w_res_out.read_valid;
    assign o_last_byte  = w_res_out.last_byte;
    assign o_busy_res   = w_res_out.busy_res;
    assign o_status     = w_res_out.status;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import iem_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int TARGET_ITEMS = 1950;

    typedef enum int {
        BUS_IDLE,
        BUS_START,
        BUS_TX_BIT,
        BUS_SLAVE_ACK,
        BUS_RX_BIT,
        BUS_MASTER_ACK,
        BUS_STOP
    } bus_phase_e;

    typedef enum int {
        SEND_DEV_WR,
        SEND_WORD,
        SEND_DATA,
        SEND_DEV_RD,
        RECV_DATA
    } byte_stage_e;

    typedef enum int {
        POP_ALWAYS,
        POP_COIN,
        POP_EVERY_4TH,
        POP_RARE
    } pop_style_e;

    // Tracks the bus engine one item at a time and holds the line levels it owes.
    class i2c_bus_tracker;
        logic [DEV_W-1:0]   dev_addr;
        logic [PHASE_W-1:0] quarter_len;
        bus_phase_e         phase;
        byte_stage_e        stage;
        int                 quarter;
        int                 tick_count;
        int                 bit_idx;
        int                 bytes_left;
        int                 fill;
        int                 send_pos;
        bit                 is_read;
        bit                 nack_seen;
        logic [7:0]         shifter;
        logic [7:0]         word_addr;
        logic [7:0]         wr_buf [BUF_DEPTH];
        t_result            now_out;
        t_result            levels_due [$];
        int                 errors;

        function new();
            dev_addr = DEV_ADDR_RESET;
            quarter_len = PHASE_RESET;
            phase = BUS_IDLE;
            stage = SEND_DEV_WR;
            quarter = 0;
            tick_count = 0;
            bit_idx = 0;
            bytes_left = 0;
            fill = 0;
            send_pos = 0;
            is_read = 1'b0;
            nack_seen = 1'b0;
            shifter = '0;
            word_addr = '0;
            foreach (wr_buf[i]) wr_buf[i] = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_DEV_ADDR)
                dev_addr = val[DEV_W-1:0];
            else
                quarter_len = val;
        endfunction

        function bit bus_busy();
            return phase != BUS_IDLE;
        endfunction

        function void load_byte(logic [7:0] b);
            shifter = b;
            bit_idx = 0;
            phase = BUS_TX_BIT;
        endfunction

        function void start_txn(bit rd, logic [7:0] addr, logic [4:0] count);
            is_read = rd;
            nack_seen = 1'b0;
            word_addr = addr;
            if (rd)
                bytes_left = (count == 0) ? 1 : int'(count);
            else
                bytes_left = (int'(count) > BUF_DEPTH) ? BUF_DEPTH : int'(count);
            send_pos = 0;
            stage = SEND_DEV_WR;
            bit_idx = 0;
            shifter = '0;
            tick_count = 0;
            quarter = 0;
            phase = BUS_START;
        endfunction

        // Work done when the fourth quarter of a bit slot closes.
        function void end_slot();
            case (phase)
                BUS_START: load_byte({dev_addr, stage == SEND_DEV_RD});
                BUS_TX_BIT: begin
                    shifter = {shifter[6:0], 1'b0};
                    bit_idx++;
                    if (bit_idx >= 8) phase = BUS_SLAVE_ACK;
                end
                BUS_SLAVE_ACK: begin
                    if (nack_seen) begin
                        phase = BUS_STOP;
                    end else if (stage == SEND_DEV_WR) begin
                        stage = SEND_WORD;
                        load_byte(word_addr);
                    end else if (stage == SEND_WORD && is_read) begin
                        stage = SEND_DEV_RD;
                        phase = BUS_START;
                    end else if (stage == SEND_DEV_RD) begin
                        stage = RECV_DATA;
                        shifter = '0;
                        bit_idx = 0;
                        phase = BUS_RX_BIT;
                    end else if (bytes_left == 0) begin
                        phase = BUS_STOP;
                    end else begin
                        load_byte(wr_buf[send_pos]);
                        send_pos++;
                        bytes_left--;
                        stage = SEND_DATA;
                    end
                end
                BUS_RX_BIT: begin
                    bit_idx++;
                    if (bit_idx >= 8) begin
                        now_out.read_data = shifter;
                        now_out.read_valid = 1'b1;
                        now_out.last_byte = (bytes_left == 1);
                        if (bytes_left > 0) bytes_left--;
                        phase = BUS_MASTER_ACK;
                    end
                end
                BUS_MASTER_ACK: begin
                    if (bytes_left == 0) begin
                        phase = BUS_STOP;
                    end else begin
                        shifter = '0;
                        bit_idx = 0;
                        phase = BUS_RX_BIT;
                    end
                end
                BUS_STOP: begin
                    phase = BUS_IDLE;
                    now_out.status = nack_seen ? STATUS_NACK : STATUS_OK;
                    if (!is_read) fill = 0;
                end
                default: phase = BUS_IDLE;
            endcase
        endfunction

        function void take_item(t_item it);
            bit busy;
            bit mid;
            int len;
            busy = bus_busy();
            now_out = '0;
            case (it.cmd)
                CMD_WRITE, CMD_READ: begin
                    if (!busy) start_txn(it.cmd == CMD_READ, it.mem_addr, it.byte_count);
                end
                CMD_LOAD: begin
                    if (!busy && fill < BUF_DEPTH) begin
                        wr_buf[fill] = it.data_byte;
                        fill++;
                    end
                end
                default: begin
                    if (busy) begin
                        len = (quarter_len == 0) ? 1 : int'(quarter_len);
                        tick_count++;
                        if (tick_count >= len) begin
                            tick_count = 0;
                            // ACK and data bits are taken at the end of the second quarter.
                            if (quarter == 1) begin
                                if (phase == BUS_SLAVE_ACK && it.sda_in)
                                    nack_seen = 1'b1;
                                else if (phase == BUS_RX_BIT)
                                    shifter = {shifter[6:0], it.sda_in};
                            end
                            if (quarter >= 3) begin
                                quarter = 0;
                                end_slot();
                            end else begin
                                quarter++;
                            end
                        end
                    end
                end
            endcase

            mid = (quarter == 1 || quarter == 2);
            case (phase)
                BUS_START: begin
                    now_out.scl_out = mid;
                    now_out.sda_low = (quarter >= 2);
                end
                BUS_TX_BIT: begin
                    now_out.scl_out = mid;
                    now_out.sda_low = !shifter[7];
                end
                BUS_SLAVE_ACK, BUS_RX_BIT: begin
                    now_out.scl_out = mid;
                    now_out.sda_low = 1'b0;
                end
                BUS_MASTER_ACK: begin
                    now_out.scl_out = mid;
                    now_out.sda_low = (bytes_left != 0);
                end
                BUS_STOP: begin
                    now_out.scl_out = (quarter >= 1);
                    now_out.sda_low = (quarter <= 1);
                end
                default: begin
                    now_out.scl_out = 1'b1;
                    now_out.sda_low = 1'b0;
                end
            endcase
            now_out.busy_res = bus_busy();
            levels_due.push_back(now_out);
        endfunction

        function void cmp(string name, logic [7:0] exp_v, logic [7:0] act_v);
            if (act_v !== exp_v) begin
                errors++;
                $display("%0t %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_levels(t_result act);
            t_result exp_r;
            if (levels_due.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none, actual %0h", $time, act);
                return;
            end
            exp_r = levels_due.pop_front();
            cmp("scl_out", 8'(exp_r.scl_out), 8'(act.scl_out));
            cmp("sda_low", 8'(exp_r.sda_low), 8'(act.sda_low));
            cmp("read_data", exp_r.read_data, act.read_data);
            cmp("read_valid", 8'(exp_r.read_valid), 8'(act.read_valid));
            cmp("last_byte", 8'(exp_r.last_byte), 8'(act.last_byte));
            cmp("busy_res", 8'(exp_r.busy_res), 8'(act.busy_res));
            cmp("status", 8'(exp_r.status), 8'(act.status));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [FUNC_W-1:0]     i_func = '0;
    logic [ADDR_W-1:0]     i_mem_addr = '0;
    logic [COUNT_W-1:0]    i_byte_count = '0;
    logic [DATA_W-1:0]     i_data_byte = '0;
    logic                  i_sda_in = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic                  o_scl_out;
    logic                  o_sda_low;
    logic [DATA_W-1:0]     o_read_data;
    logic                  o_read_valid;
    logic                  o_last_byte;
    logic                  o_busy_res;
    logic [STATUS_W-1:0]   o_status;

    i2c_bus_tracker bus_model;
    int             burst_left = 0;
    int             work_items = 0;
    int             nack_odds = 0;
    int             cycles = 0;
    pop_style_e     pop_style = POP_ALWAYS;
    int             style_left = 0;
    int             pop_count = 0;

    i2c_eeprom_master DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_func       (i_func),
        .i_mem_addr   (i_mem_addr),
        .i_byte_count (i_byte_count),
        .i_data_byte  (i_data_byte),
        .i_sda_in     (i_sda_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .empty        (empty),
        .pop          (pop),
        .o_scl_out    (o_scl_out),
        .o_sda_low    (o_sda_low),
        .o_read_data  (o_read_data),
        .o_read_valid (o_read_valid),
        .o_last_byte  (o_last_byte),
        .o_busy_res   (o_busy_res),
        .o_status     (o_status)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: check each transfer, then pick the next pop level.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            bus_model.check_levels({o_scl_out, o_sda_low, o_read_data, o_read_valid,
                                    o_last_byte, o_busy_res, o_status});
        if (style_left == 0) begin
            pop_style = pop_style_e'($urandom_range(0, 3));
            style_left = $urandom_range(16, 200);
        end
        style_left--;
        pop_count++;
        case (pop_style)
            POP_ALWAYS:    pop <= 1'b1;
            POP_COIN:      pop <= 1'($urandom_range(0, 1));
            POP_EVERY_4TH: pop <= (pop_count % 4 == 0);
            default:       pop <= ($urandom_range(0, 15) == 0);
        endcase
    end

    task automatic idle(int n);
        push <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send(t_cmd c, logic [7:0] addr, logic [4:0] cnt, logic [7:0] data,
                        logic sda);
        t_item it;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 8));
        end
        burst_left--;
        it = '{cmd: c, mem_addr: addr, byte_count: cnt, data_byte: data, sda_in: sda};
        push <= 1'b1;
        i_func <= c;
        i_mem_addr <= addr;
        i_byte_count <= cnt;
        i_data_byte <= data;
        i_sda_in <= sda;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (bus_model.bus_busy() ? c == CMD_TICK : c != CMD_TICK) work_items++;
        bus_model.take_item(it);
    endtask

    // The slave ACKs unless the NACK odds say otherwise; zero odds never NACK.
    task automatic tick();
        logic sda;
        if (bus_model.phase == BUS_SLAVE_ACK)
            sda = (nack_odds != 0) && ($urandom_range(1, nack_odds) == 1);
        else
            sda = 1'($urandom_range(0, 1));
        send(CMD_TICK, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
             8'($urandom_range(0, 255)), sda);
    endtask

    task automatic load_bytes(int n);
        repeat (n)
            send(CMD_LOAD, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic begin_txn(t_cmd c, logic [7:0] addr, logic [4:0] cnt);
        send(c, addr, cnt, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // Ticks until the bus is idle, with commands mixed in that a busy master drops.
    task automatic finish_txn();
        while (bus_model.bus_busy()) begin
            if ($urandom_range(0, 24) == 0)
                begin_txn(t_cmd'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                          5'($urandom_range(0, 31)));
            else
                tick();
        end
    endtask

    task automatic drain();
        idle(1);
        while (bus_model.levels_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reconfigure(logic [DEV_W-1:0] dev, logic [PHASE_W-1:0] qlen);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_DEV_ADDR;
        i_cfg_wdata <= CFG_DATA_W'(dev);
        @(posedge i_clk);
        i_cfg_idx <= CFG_PHASE;
        i_cfg_wdata <= qlen;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        bus_model.set_reg(CFG_DEV_ADDR, CFG_DATA_W'(dev));
        bus_model.set_reg(CFG_PHASE, qlen);
    endtask

    initial begin
        logic [4:0] cnt;
        bus_model = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, all ACKed unless stated.
        tick();
        tick();
        begin_txn(CMD_WRITE, 8'h00, 5'd0);
        begin_txn(CMD_READ, 8'h11, 5'd4);
        load_bytes(1);
        begin_txn(CMD_WRITE, 8'h22, 5'd3);
        finish_txn();

        // Seventeen loads: the last one finds the buffer full.
        for (int i = 0; i < BUF_DEPTH + 1; i++)
            send(CMD_LOAD, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                 (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
        begin_txn(CMD_WRITE, 8'hFF, 5'd31);
        finish_txn();
        begin_txn(CMD_READ, 8'hFF, 5'd0);
        finish_txn();
        begin_txn(CMD_READ, 8'h00, 5'd3);
        finish_txn();

        // The slave refuses its address on both kinds of transaction.
        nack_odds = 1;
        load_bytes(2);
        begin_txn(CMD_WRITE, 8'h5A, 5'd2);
        finish_txn();
        begin_txn(CMD_READ, 8'hA5, 5'd2);
        finish_txn();
        nack_odds = 0;

        reconfigure(7'd0, 16'd2);
        begin_txn(CMD_READ, 8'h10, 5'd1);
        finish_txn();
        reconfigure(7'h7F, 16'd0);
        load_bytes(1);
        begin_txn(CMD_WRITE, 8'h20, 5'd1);
        finish_txn();

        // Longest quarter: a few ticks only, then finish at the reset length.
        reconfigure(DEV_ADDR_RESET, 16'hFFFF);
        begin_txn(CMD_WRITE, 8'h30, 5'd0);
        repeat (40) tick();
        reconfigure(DEV_ADDR_RESET, PHASE_RESET);
        finish_txn();

        // Random transactions.
        nack_odds = 20;
        while (work_items < TARGET_ITEMS) begin
            if ($urandom_range(0, 3) == 0)
                reconfigure(7'($urandom_range(0, 127)), 16'($urandom_range(1, 3)));
            repeat ($urandom_range(0, 2)) tick();
            if ($urandom_range(0, 1) == 0) begin
                load_bytes($urandom_range(0, 4));
                cnt = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(5, 31))
                                                  : 5'($urandom_range(0, 4));
                begin_txn(CMD_WRITE, 8'($urandom_range(0, 255)), cnt);
            end else begin
                cnt = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(4, 12))
                                                  : 5'($urandom_range(0, 3));
                begin_txn(CMD_READ, 8'($urandom_range(0, 255)), cnt);
            end
            finish_txn();
        end

        drain();
        if (bus_model.errors == 0 && bus_model.levels_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[i2c_eeprom_master.f]
src/iem_pkg.sv
src/iem_front.sv
src/iem_core.sv
src/iem_rslt_q.sv
src/i2c_eeprom_master.sv
sim/tb_top.sv
